>>> rtl/png_scanline_unfilter_assert.svh
// ----------------------------------------------------------------------------
// PNG scanline unfilter assertion macros
// Clocked assertion wrappers with reset disable; empty when NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) \
        else $error(msg);

`define PSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
        else $error(msg);

`else

`define PSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define PSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/psu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared widths, filter codes, register indexes and predictor interface.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int unsigned MAX_WIDTH = 4096;
    localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
    localparam int unsigned WID_W     = 13;
    localparam int unsigned HGT_W     = 16;
    localparam int unsigned CFG_W     = 16;

    typedef logic [2:0] t_filter;

    localparam t_filter FLT_NONE  = 3'd0;
    localparam t_filter FLT_SUB   = 3'd1;
    localparam t_filter FLT_UP    = 3'd2;
    localparam t_filter FLT_AVG   = 3'd3;
    localparam t_filter FLT_PAETH = 3'd4;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_ALPHA  = 2'd2;

    typedef struct packed {
        t_filter    filter;
        logic [7:0] left;
        logic [7:0] above;
        logic [7:0] upper_left;
        logic [7:0] raw;
    } t_pred_in;

endpackage

>>> rtl/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reverses PNG row filters on an 8-bit RGB/RGBA byte stream.
// ----------------------------------------------------------------------------
// Input stream: one inflated byte per beat; each row is a filter byte then
// width pixels of 3 or 4 sample bytes. Output stream: one beat per completed
// pixel, R in the low byte, A in the top byte (255 for RGB), tlast on the
// last pixel of a row, tuser carrying image end and bad filter flags.
// Throughput is one input byte per cycle, set by the combinational predictor
// and the line store, which is read one pixel ahead at the next column and
// written once per pixel. A pixel appears on the output in the cycle after
// its last byte is accepted. If the receiver stalls with a pixel held, the
// input stalls. Width, height and alpha mode are written through the config
// port; the user must write them only while the stream is idle, which the
// block does not enforce. Reset clears the row state and expects a filter
// byte; the line store is not cleared (each image's first row reads zeros).
// ----------------------------------------------------------------------------
module png_scanline_unfilter
    import psu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] data_byte
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] pixel
    output logic             o_m_axis_tlast,   // row_end
    output logic [1:0]       o_m_axis_tuser    // [0] image_end, [1] bad_filter
);

`include "png_scanline_unfilter_assert.svh"

    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic             r_alpha;

    logic [31:0]      r_left,    n_left;
    logic [31:0]      r_ul,      n_ul;
    logic [31:0]      r_partial, n_partial;
    t_filter          r_filter,  n_filter;
    logic             r_flagged, n_flagged;
    logic [2:0]       r_byte_idx, n_byte_idx;
    logic [COL_W-1:0] r_column,  n_column;
    logic [HGT_W-1:0] r_row_cnt, n_row_cnt;
    logic             r_first,   n_first;

    logic             r_out_valid;
    logic [31:0]      r_out_pixel;
    logic             r_out_last;
    logic [1:0]       r_out_user;

    logic [31:0]      mem_line [MAX_WIDTH];
    logic [31:0]      r_rd_data;
    logic             r_byp_hit;
    logic [31:0]      r_byp_data;

    logic             w_accept;
    logic [WID_W-1:0] w_width;
    logic [HGT_W-1:0] w_height;
    logic [1:0]       w_chan;
    logic             w_last_chan;
    logic [31:0]      w_above;
    t_pred_in         w_pred;
    logic [7:0]       w_recon;
    logic [31:0]      w_new_partial;
    logic [31:0]      w_px;
    logic             w_row_end;
    logic             w_img_end;
    logic             w_complete;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(1);
            r_height <= HGT_W'(1);
            r_alpha  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_width  <= i_cfg_wdata[WID_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_wdata[HGT_W-1:0];
                CFG_ALPHA:  r_alpha  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_width == '0) begin
            w_width = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_width = WID_W'(MAX_WIDTH);
        end else begin
            w_width = r_width;
        end
        w_height = (r_height == '0) ? HGT_W'(1) : r_height;
    end

    assign w_chan      = r_byte_idx[1:0] - 2'd1;
    assign w_last_chan = r_alpha ? (w_chan == 2'd3) : (w_chan >= 2'd2);
    assign w_above     = r_first ? 32'd0 : (r_byp_hit ? r_byp_data : r_rd_data);

    assign w_pred.filter     = r_filter;
    assign w_pred.left       = r_left[8*w_chan +: 8];
    assign w_pred.above      = w_above[8*w_chan +: 8];
    assign w_pred.upper_left = r_ul[8*w_chan +: 8];
    assign w_pred.raw        = i_s_axis_tdata;

    psu_predict u_predict (
        .i_pred  (w_pred),
        .o_recon (w_recon)
    );

    always_comb begin
        w_new_partial = r_partial;
        w_new_partial[8*w_chan +: 8] = w_recon;
    end

    assign w_px       = r_alpha ? w_new_partial : {8'hFF, w_new_partial[23:0]};
    assign w_row_end  = (WID_W'(r_column) + WID_W'(1)) >= w_width;
    assign w_img_end  = w_row_end
                        && (({1'b0, r_row_cnt} + 17'd1) >= {1'b0, w_height});
    assign w_complete = w_accept && (r_byte_idx != 3'd0) && w_last_chan;

    always_comb begin
        n_left     = r_left;
        n_ul       = r_ul;
        n_partial  = r_partial;
        n_filter   = r_filter;
        n_flagged  = r_flagged;
        n_byte_idx = r_byte_idx;
        n_column   = r_column;
        n_row_cnt  = r_row_cnt;
        n_first    = r_first;
        if (w_accept) begin
            if (r_byte_idx == 3'd0) begin
                if (i_s_axis_tdata > 8'd4) begin
                    n_filter  = FLT_NONE;
                    n_flagged = 1'b1;
                end else begin
                    n_filter  = t_filter'(i_s_axis_tdata[2:0]);
                    n_flagged = 1'b0;
                end
                n_partial  = 32'd0;
                n_byte_idx = 3'd1;
            end else if (!w_last_chan) begin
                n_partial  = w_new_partial;
                n_byte_idx = r_byte_idx + 3'd1;
            end else begin
                n_partial  = 32'd0;
                n_byte_idx = 3'd1;
                n_ul       = w_above;
                n_left     = w_px;
                if (w_row_end) begin
                    n_column   = '0;
                    n_left     = 32'd0;
                    n_ul       = 32'd0;
                    n_byte_idx = 3'd0;
                    if (w_img_end) begin
                        n_row_cnt = '0;
                        n_first   = 1'b1;
                    end else begin
                        n_row_cnt = r_row_cnt + HGT_W'(1);
                        n_first   = 1'b0;
                    end
                end else begin
                    n_column = r_column + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= 32'd0;
            r_ul       <= 32'd0;
            r_partial  <= 32'd0;
            r_filter   <= FLT_NONE;
            r_flagged  <= 1'b0;
            r_byte_idx <= 3'd0;
            r_column   <= '0;
            r_row_cnt  <= '0;
            r_first    <= 1'b1;
        end else begin
            r_left     <= n_left;
            r_ul       <= n_ul;
            r_partial  <= n_partial;
            r_filter   <= n_filter;
            r_flagged  <= n_flagged;
            r_byte_idx <= n_byte_idx;
            r_column   <= n_column;
            r_row_cnt  <= n_row_cnt;
            r_first    <= n_first;
        end
    end

    // Line store: write the finished pixel, prefetch the next column
    always_ff @(posedge i_clk) begin
        if (w_complete) begin
            mem_line[r_column] <= w_px;
        end
        r_rd_data  <= mem_line[n_column];
        r_byp_data <= w_px;
    end

    // Forward a pixel written to the column being prefetched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= w_complete && (r_column == n_column);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_complete) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_complete) begin
            r_out_pixel <= w_px;
            r_out_last  <= w_row_end;
            r_out_user  <= {r_flagged, w_img_end};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pixel;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

    `PSU_ASSERT_NOW(a_img_end_is_row_end, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tlast, "image end without row end")
    `PSU_ASSERT_NOW(a_filter_at_col0, i_clk, i_rst_n, r_byte_idx == 3'd0, r_column == '0, "filter byte expected mid-row")
    `PSU_ASSERT_NOW(a_first_row_count, i_clk, i_rst_n, r_first, r_row_cnt == '0, "first row with nonzero row count")
    `PSU_ASSERT_NEXT(a_pixel_out, i_clk, i_rst_n, w_complete, o_m_axis_tvalid, "completed pixel not presented")

endmodule

>>> rtl/psu_predict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter byte predictor
// Reconstructs one sample byte from the raw byte and its three neighbors.
// ----------------------------------------------------------------------------
module psu_predict
    import psu_pkg::*;
(
    input  t_pred_in   i_pred,
    output logic [7:0] o_recon
);

    logic signed [9:0] w_a;
    logic signed [9:0] w_b;
    logic signed [9:0] w_c;
    logic signed [9:0] w_pa;
    logic signed [9:0] w_pb;
    logic signed [9:0] w_pc;
    logic [8:0]        w_sum;
    logic [7:0]        w_paeth;
    logic [7:0]        w_pred;

    assign w_a = signed'({2'b00, i_pred.left});
    assign w_b = signed'({2'b00, i_pred.above});
    assign w_c = signed'({2'b00, i_pred.upper_left});

    always_comb begin
        w_pa = w_b - w_c;
        w_pb = w_a - w_c;
        w_pc = w_a + w_b - w_c - w_c;
        if (w_pa < 0) w_pa = -w_pa;
        if (w_pb < 0) w_pb = -w_pb;
        if (w_pc < 0) w_pc = -w_pc;
        if (w_pa <= w_pb && w_pa <= w_pc) begin
            w_paeth = i_pred.left;
        end else if (w_pb <= w_pc) begin
            w_paeth = i_pred.above;
        end else begin
            w_paeth = i_pred.upper_left;
        end
    end

    assign w_sum = {1'b0, i_pred.left} + {1'b0, i_pred.above};

    always_comb begin
        case (i_pred.filter)
            FLT_SUB:   w_pred = i_pred.left;
            FLT_UP:    w_pred = i_pred.above;
            FLT_AVG:   w_pred = w_sum[8:1];
            FLT_PAETH: w_pred = w_paeth;
            default:   w_pred = 8'd0;
        endcase
    end

    assign o_recon = i_pred.raw + w_pred;

endmodule

>>> verif/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams directed and random filtered rows through the unfilter over
// several width, height and alpha settings, predicts each reconstructed
// pixel with an in-bench unfilter model and checks every output beat in
// order, with random idle gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
    import psu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned RAND_BYTES  = 320;

    typedef struct {
        logic [31:0] pixel;
        logic        row_end;
        logic        image_end;
        logic        bad_filter;
    } pixel_beat_t;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    t_cfg_idx         i_cfg_addr  = CFG_WIDTH;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             s_valid     = 1'b0;
    logic [7:0]       s_data      = '0;
    logic             m_ready     = 1'b0;
    logic             s_ready;
    logic             m_valid;
    logic [31:0]      m_data;
    logic             m_last;
    logic [1:0]       m_user;

    png_scanline_unfilter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    logic [7:0]  byte_q [$];
    pixel_beat_t pixel_q [$];
    int unsigned err_cnt = 0;

    logic        s_fire  = 1'b0;
    logic        m_fire  = 1'b0;
    int unsigned s_gap   = 0;
    int unsigned m_hold  = 0;
    bit          s_burst = 1'b0;
    bit          m_burst = 1'b0;

    // unfilter model state
    logic [31:0] prev_row [0:MAX_WIDTH-1];
    logic [31:0] left_px   = '0;
    logic [31:0] upleft_px = '0;
    logic [31:0] part_px   = '0;
    t_filter     row_filt  = FLT_NONE;
    logic        row_bad   = 1'b0;
    int unsigned next_chan = 0;
    int unsigned col       = 0;
    int unsigned rows_done = 0;
    logic        top_row   = 1'b1;
    int unsigned cfg_width  = 1;
    int unsigned cfg_height = 1;
    logic        cfg_alpha  = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_wait(inout bit burst);
        if ($urandom_range(0, 31) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = p - int'(a);
        pb = p - int'(b);
        pc = p - int'(c);
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    task automatic unfilter_byte(input logic [7:0] d);
        int unsigned width, height, bpp, ch;
        logic [31:0] above, px;
        logic [7:0]  a, b, c, pred;
        pixel_beat_t beat;
        width  = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        height = (cfg_height == 0) ? 1 : cfg_height;
        bpp    = cfg_alpha ? 4 : 3;
        if (next_chan == 0) begin
            if (d > FLT_PAETH) begin
                row_filt = FLT_NONE;
                row_bad  = 1'b1;
            end else begin
                row_filt = t_filter'(d);
                row_bad  = 1'b0;
            end
            part_px   = '0;
            next_chan = 1;
        end else begin
            ch    = next_chan - 1;
            above = (top_row || col >= MAX_WIDTH) ? '0 : prev_row[col];
            a     = left_px[8*ch +: 8];
            b     = above[8*ch +: 8];
            c     = upleft_px[8*ch +: 8];
            case (row_filt)
                FLT_SUB:   pred = a;
                FLT_UP:    pred = b;
                FLT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
                FLT_PAETH: pred = paeth_pick(a, b, c);
                default:   pred = '0;
            endcase
            part_px[8*ch +: 8] = d + pred;
            if (ch + 1 < bpp) begin
                next_chan = ch + 2;
            end else begin
                px = part_px;
                if (!cfg_alpha) px[31:24] = 8'hFF;
                prev_row[col]   = px;
                upleft_px       = above;
                left_px         = px;
                part_px         = '0;
                next_chan       = 1;
                beat.pixel      = px;
                beat.row_end    = (col + 1 >= width);
                beat.image_end  = beat.row_end && (rows_done + 1 >= height);
                beat.bad_filter = row_bad;
                pixel_q.push_back(beat);
                if (beat.row_end) begin
                    col       = 0;
                    left_px   = '0;
                    upleft_px = '0;
                    next_chan = 0;
                    if (beat.image_end) begin
                        rows_done = 0;
                        top_row   = 1'b1;
                    end else begin
                        rows_done = (rows_done + 1) & 16'hFFFF;
                        top_row   = 1'b0;
                    end
                end else begin
                    col = col + 1;
                end
            end
        end
    endtask

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : monitor
        pixel_beat_t want;
        s_fire <= i_rst_n && s_valid && s_ready;
        m_fire <= i_rst_n && m_valid && m_ready;
        if (i_rst_n) begin
            if (s_valid && s_ready) unfilter_byte(s_data);
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    flag_error($sformatf("unexpected pixel beat: data %h last %b user %b",
                                         m_data, m_last, m_user));
                end else begin
                    want = pixel_q.pop_front();
                    if (m_data !== want.pixel || m_last !== want.row_end ||
                        m_user[0] !== want.image_end || m_user[1] !== want.bad_filter) begin
                        flag_error($sformatf(
                            "pixel mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b (px/row/img/bad)",
                            want.pixel, want.row_end, want.image_end, want.bad_filter,
                            m_data, m_last, m_user[0], m_user[1]));
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin : byte_driver
        if (i_rst_n && !(s_valid && !s_fire)) begin
            if (s_gap > 0) begin
                s_valid <= 1'b0;
                s_gap   <= s_gap - 1;
            end else if (byte_q.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= byte_q.pop_front();
                s_gap   <= draw_wait(s_burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : pixel_sink
        int unsigned hold_n;
        hold_n = m_fire ? draw_wait(m_burst) : m_hold;
        if (hold_n > 0) begin
            m_ready <= 1'b0;
            m_hold  <= hold_n - 1;
        end else begin
            m_ready <= 1'b1;
            m_hold  <= 0;
        end
    end

    initial begin : watchdog
        int unsigned cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= CFG_W'(value);
        case (idx)
            CFG_WIDTH:  cfg_width  = value & 16'h1FFF;
            CFG_HEIGHT: cfg_height = value & 16'hFFFF;
            default:    cfg_alpha  = value[0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h, input bit alpha);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_ALPHA, alpha);
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || s_valid || pixel_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // push rows of random filter and sample bytes; return the byte count
    task automatic queue_rows(input int unsigned rows, input int unsigned w,
                              input int unsigned bpp, output int unsigned count);
        count = 0;
        repeat (rows) begin
            if ($urandom_range(0, 9) == 0) byte_q.push_back(8'($urandom_range(0, 255)));
            else byte_q.push_back(8'($urandom_range(0, 4)));
            repeat (w * bpp) byte_q.push_back(rand_sample());
            count += 1 + w * bpp;
        end
    endtask

    initial begin : stimulus
        logic [7:0]  directed [24];
        int unsigned rand_total, n, w, h;
        bit          alpha;
        directed = '{8'(FLT_UP),    8'h00, 8'hFF, 8'h80,
                     8'(FLT_NONE),  8'hFF, 8'hFF, 8'hFF,
                     8'(FLT_SUB),   8'h01, 8'h00, 8'hFF,
                     8'(FLT_AVG),   8'hFF, 8'h01, 8'h7F,
                     8'(FLT_PAETH), 8'h00, 8'hFF, 8'h55,
                     8'hFF,         8'hAA, 8'h55, 8'h00};
        rand_total = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_image(1, 6, 1'b0);
        foreach (directed[k]) byte_q.push_back(directed[k]);

        while (rand_total < RAND_BYTES) begin
            w     = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            h     = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
            alpha = $urandom_range(0, 1);
            wait_drained();
            set_image(w, h, alpha);
            queue_rows((h == 0) ? 1 : h, (w == 0) ? 1 : w, alpha ? 4 : 3, n);
            rand_total += n;
        end

        // tallest image, left open at the end of the run
        wait_drained();
        w = $urandom_range(1, 4);
        set_image(w, 65535, 1'b1);
        queue_rows(5, w, 4, n);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && pixel_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> png_scanline_unfilter.f
+incdir+rtl
rtl/psu_pkg.sv
rtl/psu_predict.sv
rtl/png_scanline_unfilter.sv
verif/tb_png_scanline_unfilter.sv
